// File: hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps

package kts_pkg;

   // Field widths of the request and response payloads.
   localparam int unsigned COORD_W    = 5;
   localparam int unsigned AREA_W     = 10;
   localparam int unsigned MOVE_W     = 4;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // Move counter value once all eight knight moves have been tried.
   localparam logic [MOVE_W-1:0] MOVE_DONE = 4'd8;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_SQUARE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_TOUR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_STEP,
      S_POP_LOAD,
      S_FAIL,
      S_SAVE,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic init;
      logic try_move;
      logic pop;
      logic load_top;
      logic save_top;
      logic clear_emit;
      logic emit_read;
      logic emit_square;
      logic emit_big;
      logic emit_none;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic area_big;
      logic area_zero;
      logic depth_full;
      logic depth_one;
      logic move_done;
      logic out_empty;
      logic emit_last;
   } status_type;

   // Knight move offsets, ordered so landing squares come in column-then-row order.
   function automatic logic signed [2:0] col_step(input logic [2:0] m);
      logic signed [2:0] s;
      unique case (m)
         3'd0, 3'd1: s = -3'sd2;
         3'd2, 3'd3: s = -3'sd1;
         3'd4, 3'd5: s = 3'sd1;
         3'd6, 3'd7: s = 3'sd2;
      endcase
      return s;
   endfunction

   function automatic logic signed [2:0] row_step(input logic [2:0] m);
      logic signed [2:0] s;
      unique case (m)
         3'd0, 3'd6: s = -3'sd1;
         3'd1, 3'd7: s = 3'sd1;
         3'd2, 3'd4: s = -3'sd2;
         3'd3, 3'd5: s = 3'sd2;
      endcase
      return s;
   endfunction

endpackage

// File: hw/rtl/knight_tour_search_unit.sv
`timescale 1ns / 1ps

// Knight's tour search unit.
// A request on the req_ channel carries a board size (rows, columns). The unit searches
// depth first, with backtracking, for an open knight's tour starting at A1, trying the
// moves from each square in order of landing column, then landing row.
// On success it returns one response per square in visiting order on the rsp_ channel,
// status 0 (tour square), with tlast on the final square. If no tour exists it returns
// a single response with status 1; if rows times columns exceeds MAX_SQUARES it returns
// a single response with status 2 and runs no search. Single responses carry tlast.
// One request is processed at a time. After acceptance, a check state tests the board
// size and sets up the search; then each move tried takes a step state and each
// backtrack a step state and a pop-load state (the stack memory read is registered). The
// total time is therefore set by the number of moves the search explores. Emission
// reads each square from the stack memory into the response register, which is refilled
// only after it has drained, so a new square is not loaded while the last one is unread.
// The response register decouples the sides: the last response of one request may sit
// unread while the next request is accepted and searched. When the receiver stalls,
// emission waits with the pending response held stable.
// Reset (synchronous, active high) returns the unit to idle with no response pending.
module knight_tour_search_unit #(
   parameter int unsigned MAX_SQUARES = 32
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream: tdata [4:0] board_rows, [9:5] board_cols, [15:10] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // Response stream: tdata [4:0] square_col, [9:5] square_row, [15:10] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // Response kind: tuser [1:0] status.
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   kts_pkg::cmd_type    cmd;
   kts_pkg::status_type stat;

   logic [kts_pkg::COORD_W-1:0]  rsp_col;
   logic [kts_pkg::COORD_W-1:0]  rsp_row;
   logic [kts_pkg::STATUS_W-1:0] rsp_status;

   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kts_datapath #(
      .MAX_SQUARES (MAX_SQUARES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_rows   (req_tdata[4:0]),
      .req_cols   (req_tdata[9:5]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_col    (rsp_col),
      .rsp_row    (rsp_row),
      .rsp_last   (rsp_tlast)
   );

   // The payload is packed here: column in the low bits, then row, zero padding above.
   assign rsp_tdata = {6'b000000, rsp_row, rsp_col};
   assign rsp_tuser = rsp_status;

endmodule

// File: hw/rtl/kts_ctrl.sv
`timescale 1ns / 1ps

module kts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  kts_pkg::status_type stat,
   output kts_pkg::cmd_type    cmd
);

   kts_pkg::state_type state_ff;
   kts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            if (req_tvalid) state_in = kts_pkg::S_CHECK;
         end
         kts_pkg::S_CHECK: begin
            if (stat.area_big || stat.area_zero) begin
               if (stat.out_empty) state_in = kts_pkg::S_IDLE;
            end else begin
               state_in = kts_pkg::S_STEP;
            end
         end
         kts_pkg::S_STEP: begin
            priority if (stat.depth_full) begin
               state_in = kts_pkg::S_SAVE;
            end else if (stat.move_done) begin
               state_in = stat.depth_one ? kts_pkg::S_FAIL : kts_pkg::S_POP_LOAD;
            end
         end
         kts_pkg::S_POP_LOAD: state_in = kts_pkg::S_STEP;
         kts_pkg::S_FAIL: begin
            if (stat.out_empty) state_in = kts_pkg::S_IDLE;
         end
         kts_pkg::S_SAVE: state_in = kts_pkg::S_EMIT_RD;
         kts_pkg::S_EMIT_RD: begin
            if (stat.out_empty) state_in = kts_pkg::S_EMIT_LD;
         end
         kts_pkg::S_EMIT_LD: begin
            state_in = stat.emit_last ? kts_pkg::S_IDLE : kts_pkg::S_EMIT_RD;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         kts_pkg::S_CHECK: begin
            if (stat.area_big || stat.area_zero) begin
               cmd.emit_big  = stat.out_empty && stat.area_big;
               cmd.emit_none = stat.out_empty && !stat.area_big;
            end else begin
               cmd.init = 1'b1;
            end
         end
         kts_pkg::S_STEP: begin
            priority if (stat.depth_full) begin
               cmd.try_move = 1'b0;
            end else if (stat.move_done) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.try_move = 1'b1;
            end
         end
         kts_pkg::S_POP_LOAD: cmd.load_top = 1'b1;
         kts_pkg::S_FAIL:     cmd.emit_none = stat.out_empty;
         kts_pkg::S_SAVE: begin
            cmd.save_top   = 1'b1;
            cmd.clear_emit = 1'b1;
         end
         kts_pkg::S_EMIT_RD:  cmd.emit_read = stat.out_empty;
         kts_pkg::S_EMIT_LD:  cmd.emit_square = 1'b1;
      endcase
   end

endmodule

// File: hw/rtl/kts_datapath.sv
`timescale 1ns / 1ps

module kts_datapath #(
   parameter int unsigned MAX_SQUARES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [kts_pkg::COORD_W-1:0]         req_rows,
   input  logic [kts_pkg::COORD_W-1:0]         req_cols,
   input  kts_pkg::cmd_type                    cmd,
   output kts_pkg::status_type                 stat,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [kts_pkg::STATUS_W-1:0]        rsp_status,
   output logic [kts_pkg::COORD_W-1:0]         rsp_col,
   output logic [kts_pkg::COORD_W-1:0]         rsp_row,
   output logic                                rsp_last
);

   localparam int unsigned CW      = kts_pkg::COORD_W;
   localparam int unsigned MW      = kts_pkg::MOVE_W;
   localparam int unsigned AW      = kts_pkg::AREA_W;
   localparam int unsigned IDX_W   = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
   localparam int unsigned DEP_W   = $clog2(MAX_SQUARES + 1);
   localparam int unsigned ENTRY_W = 2 * CW + MW + IDX_W;
   localparam int unsigned NC_W    = CW + 2;
   localparam int unsigned OFF_W   = 12;

   // Board geometry of the current request.
   logic [CW-1:0]          rows_ff;
   logic [CW-1:0]          cols_ff;
   logic [AW-1:0]          area_ff;

   // Top of the path, kept in registers; the squares below it live in the stack memory.
   logic [CW-1:0]          top_col_ff,  top_col_in;
   logic [CW-1:0]          top_row_ff,  top_row_in;
   logic [MW-1:0]          top_move_ff, top_move_in;
   logic [IDX_W-1:0]       top_idx_ff,  top_idx_in;
   logic [DEP_W-1:0]       depth_ff,    depth_in;
   logic [MAX_SQUARES-1:0] visited_ff,  visited_in;
   logic [IDX_W-1:0]       emit_k_ff;

   logic [ENTRY_W-1:0]     stack_mem [MAX_SQUARES];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   mem_we;
   logic                   mem_re;
   logic [IDX_W-1:0]       mem_waddr;
   logic [IDX_W-1:0]       mem_raddr;
   logic [ENTRY_W-1:0]     mem_wdata;

   logic                   rsp_valid_ff;
   logic [kts_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CW-1:0]          rsp_col_ff;
   logic [CW-1:0]          rsp_row_ff;
   logic                   rsp_last_ff;

   // Candidate landing square for the move under trial.
   logic signed [2:0]      dc;
   logic signed [2:0]      dr;
   logic signed [NC_W-1:0] nc;
   logic signed [NC_W-1:0] nr;
   logic [CW:0]            row_mag;
   logic signed [OFF_W-1:0] row_off;
   logic signed [OFF_W-1:0] cand_idx;
   logic [IDX_W-1:0]       cand_sel;
   logic                   cand_ok;
   logic [MW-1:0]          move_plus;
   logic [DEP_W-1:0]       depth_m1;
   logic [DEP_W-1:0]       depth_m2;
   logic [AW-1:0]          area_req;
   logic [CW-1:0]          rd_col;
   logic [CW-1:0]          rd_row;
   logic [MW-1:0]          rd_move;
   logic [IDX_W-1:0]       rd_idx;

   assign area_req = AW'(req_rows) * AW'(req_cols);

   assign dc = kts_pkg::col_step(top_move_ff[2:0]);
   assign dr = kts_pkg::row_step(top_move_ff[2:0]);
   assign nc = $signed({2'b00, top_col_ff}) + NC_W'(dc);
   assign nr = $signed({2'b00, top_row_ff}) + NC_W'(dr);

   // Linear index moves by dr*cols + dc; |dr| is one or two, so a shift does it.
   assign row_mag  = (dr == 3'sd2 || dr == -3'sd2) ? {cols_ff, 1'b0} : {1'b0, cols_ff};
   assign row_off  = dr[2] ? -$signed({{(OFF_W-CW-1){1'b0}}, row_mag})
                           : $signed({{(OFF_W-CW-1){1'b0}}, row_mag});
   assign cand_idx = $signed({{(OFF_W-IDX_W){1'b0}}, top_idx_ff}) + row_off + OFF_W'(dc);
   assign cand_sel = cand_idx[IDX_W-1:0];

   assign cand_ok = !nc[NC_W-1] && (nc[CW:0] < {1'b0, cols_ff})
                 && !nr[NC_W-1] && (nr[CW:0] < {1'b0, rows_ff})
                 && !visited_ff[cand_sel];

   assign move_plus = top_move_ff + MW'(1);
   assign depth_m1  = depth_ff - DEP_W'(1);
   assign depth_m2  = depth_ff - DEP_W'(2);

   assign {rd_col, rd_row, rd_move, rd_idx} = rd_data_ff;

   // Stack memory: pushes and the final top save write, backtracks and emission read.
   assign mem_we    = (cmd.try_move && cand_ok) || cmd.save_top;
   assign mem_waddr = IDX_W'(depth_m1);
   assign mem_wdata = {top_col_ff, top_row_ff, move_plus, top_idx_ff};
   assign mem_re    = cmd.pop || cmd.emit_read;
   assign mem_raddr = cmd.pop ? IDX_W'(depth_m2) : emit_k_ff;

   always_ff @(posedge clock) begin
      if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= stack_mem[mem_raddr];
   end

   always_comb begin
      top_col_in  = top_col_ff;
      top_row_in  = top_row_ff;
      top_move_in = top_move_ff;
      top_idx_in  = top_idx_ff;
      depth_in    = depth_ff;
      visited_in  = visited_ff;
      priority if (cmd.init) begin
         top_col_in  = '0;
         top_row_in  = '0;
         top_move_in = '0;
         top_idx_in  = '0;
         depth_in    = DEP_W'(1);
         visited_in  = MAX_SQUARES'(1);
      end else if (cmd.try_move) begin
         if (cand_ok) begin
            top_col_in           = nc[CW-1:0];
            top_row_in           = nr[CW-1:0];
            top_move_in          = '0;
            top_idx_in           = cand_sel;
            depth_in             = depth_ff + DEP_W'(1);
            visited_in[cand_sel] = 1'b1;
         end else begin
            top_move_in = move_plus;
         end
      end else if (cmd.pop) begin
         visited_in[top_idx_ff] = 1'b0;
         depth_in               = depth_m1;
      end else if (cmd.load_top) begin
         top_col_in  = rd_col;
         top_row_in  = rd_row;
         top_move_in = rd_move;
         top_idx_in  = rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         visited_ff <= '0;
      end else begin
         depth_ff   <= depth_in;
         visited_ff <= visited_in;
      end
      top_col_ff  <= top_col_in;
      top_row_ff  <= top_row_in;
      top_move_ff <= top_move_in;
      top_idx_ff  <= top_idx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rows_ff <= req_rows;
         cols_ff <= req_cols;
         area_ff <= area_req;
      end
      if (cmd.clear_emit) begin
         emit_k_ff <= '0;
      end else if (cmd.emit_square) begin
         emit_k_ff <= emit_k_ff + IDX_W'(1);
      end
   end

   // Response register; it is loaded only while empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_square || cmd.emit_big || cmd.emit_none) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_square) begin
         rsp_status_ff <= kts_pkg::ST_SQUARE;
         rsp_col_ff    <= rd_col;
         rsp_row_ff    <= rd_row;
         rsp_last_ff   <= stat.emit_last;
      end else if (cmd.emit_big || cmd.emit_none) begin
         rsp_status_ff <= cmd.emit_big ? kts_pkg::ST_TOO_BIG : kts_pkg::ST_NO_TOUR;
         rsp_col_ff    <= '0;
         rsp_row_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign stat.area_big   = area_ff > AW'(MAX_SQUARES);
   assign stat.area_zero  = area_ff == '0;
   assign stat.depth_full = AW'(depth_ff) == area_ff;
   assign stat.depth_one  = depth_ff == DEP_W'(1);
   assign stat.move_done  = top_move_ff == kts_pkg::MOVE_DONE;
   assign stat.out_empty  = !rsp_valid_ff;
   assign stat.emit_last  = AW'(emit_k_ff) == (area_ff - AW'(1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_col    = rsp_col_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
